>>> src/assert_macros.svh
// Assertion macros shared by the deframer modules.
// Each macro samples on posedge clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property checked at every clock edge outside reset.
`define WSD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define WSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; used by every module.
package wsd_pkg;

    // Opcodes of the frame header
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    // Frame kind codes reported on the result
    localparam logic [2:0] KIND_TEXT        = 3'd0;
    localparam logic [2:0] KIND_TEXT_PART   = 3'd1;
    localparam logic [2:0] KIND_BINARY      = 3'd2;
    localparam logic [2:0] KIND_BINARY_PART = 3'd3;
    localparam logic [2:0] KIND_CLOSE       = 3'd4;
    localparam logic [2:0] KIND_PING        = 3'd5;
    localparam logic [2:0] KIND_PONG        = 3'd6;
    localparam logic [2:0] KIND_ERROR       = 3'd7;

    // Seven-bit length codes
    localparam logic [6:0] LEN_MAX_SHORT = 7'd125;
    localparam logic [6:0] LEN_EXT16     = 7'd126;

    // Extended length byte counts
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;

    localparam logic [2:0] MASK_LAST_IDX = 3'd3;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [2:0]  frame_kind;
        logic [63:0] payload_length;
        logic        last_byte;
        logic        empty_frame;
    } result_t;

    function automatic logic [2:0] kind_of(input logic [3:0] opcode, input logic fin);
        logic [2:0] kind;
        unique case (opcode)
            OP_CONT, OP_TEXT: kind = fin ? KIND_TEXT : KIND_TEXT_PART;
            OP_BINARY:        kind = fin ? KIND_BINARY : KIND_BINARY_PART;
            OP_CLOSE:         kind = KIND_CLOSE;
            OP_PING:          kind = KIND_PING;
            OP_PONG:          kind = KIND_PONG;
            default:          kind = KIND_ERROR;
        endcase
        return kind;
    endfunction

endpackage

>>> src/wsd_ifs.sv
// Valid/ready channel interfaces of the deframer: raw byte beats in,
// deframed result beats out. Depends on nothing.
interface wsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface wsd_frame_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic [2:0]  frame_kind;
    logic [63:0] payload_length;
    logic        last_byte;
    logic        empty_frame;

    modport source (output valid, output payload_byte, output frame_kind,
                    output payload_length, output last_byte, output empty_frame,
                    input ready);
    modport sink   (input valid, input payload_byte, input frame_kind,
                    input payload_length, input last_byte, input empty_frame,
                    output ready);
endinterface

>>> src/wsd_parser.sv
// Header parser and payload unmasker: holds the frame state and works out
// the result of each accepted byte. Depends on wsd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wsd_parser
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic [7:0]       data_byte,
    output logic             res_valid,
    output wsd_pkg::result_t res
);

    typedef enum logic [4:0] {
        PH_HEAD1   = 5'b00001,
        PH_HEAD2   = 5'b00010,
        PH_EXTLEN  = 5'b00100,
        PH_MASK    = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } phase_t;

    phase_t      phase_reg,   phase_next;
    logic [3:0]  opcode_reg,  opcode_next;
    logic        fin_reg,     fin_next;
    logic        masked_reg,  masked_next;
    logic [6:0]  code_reg,    code_next;
    logic [2:0]  count_reg,   count_next;
    logic [63:0] length_reg,  length_next;
    logic [31:0] key_reg,     key_next;
    logic [63:0] index_reg,   index_next;

    logic        length_done;
    logic        start_payload;
    logic [3:0]  need;
    logic [3:0]  count_inc;
    logic [63:0] index_inc;
    logic [7:0]  key_byte;
    logic        last;

    always_comb
    begin
        phase_next    = phase_reg;
        opcode_next   = opcode_reg;
        fin_next      = fin_reg;
        masked_next   = masked_reg;
        code_next     = code_reg;
        count_next    = count_reg;
        length_next   = length_reg;
        key_next      = key_reg;
        index_next    = index_reg;
        length_done   = 1'b0;
        start_payload = 1'b0;
        res_valid     = 1'b0;
        res.payload_byte = '0;
        res.last_byte    = 1'b0;
        res.empty_frame  = 1'b0;

        need      = (code_reg == wsd_pkg::LEN_EXT16) ? wsd_pkg::EXT16_BYTES
                                                     : wsd_pkg::EXT64_BYTES;
        count_inc = {1'b0, count_reg} + 4'd1;
        index_inc = index_reg + 64'd1;
        last      = (index_inc == length_reg);

        // key byte in wire order: first mask byte sits in the top byte
        unique case (index_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase

        unique case (phase_reg)
            PH_HEAD2:
            begin
                masked_next = data_byte[7];
                code_next   = data_byte[6:0];
                count_next  = '0;
                if (data_byte[6:0] <= wsd_pkg::LEN_MAX_SHORT)
                begin
                    length_next = {57'd0, data_byte[6:0]};
                    length_done = 1'b1;
                end
                else
                begin
                    length_next = '0;
                    phase_next  = PH_EXTLEN;
                end
            end
            PH_EXTLEN:
            begin
                // big-endian: earlier bytes move up
                length_next = {length_reg[55:0], data_byte};
                if (count_inc >= need)
                    length_done = 1'b1;
                else
                    count_next = count_inc[2:0];
            end
            PH_MASK:
            begin
                key_next = {key_reg[23:0], data_byte};
                if (count_reg >= wsd_pkg::MASK_LAST_IDX)
                    start_payload = 1'b1;
                else
                    count_next = count_inc[2:0];
            end
            PH_PAYLOAD:
            begin
                index_next       = index_inc;
                res_valid        = 1'b1;
                res.payload_byte = masked_reg ? (data_byte ^ key_byte) : data_byte;
                res.last_byte    = last;
                if (last)
                    phase_next = PH_HEAD1;
            end
            default:
            begin
                opcode_next = data_byte[3:0];
                fin_next    = data_byte[7];
                phase_next  = PH_HEAD2;
            end
        endcase

        if (length_done)
        begin
            if (masked_next)
            begin
                count_next = '0;
                key_next   = '0;
                phase_next = PH_MASK;
            end
            else
            begin
                start_payload = 1'b1;
            end
        end

        if (start_payload)
        begin
            index_next = '0;
            if (length_next == 64'd0)
            begin
                res_valid       = 1'b1;
                res.last_byte   = 1'b1;
                res.empty_frame = 1'b1;
                phase_next      = PH_HEAD1;
            end
            else
            begin
                phase_next = PH_PAYLOAD;
            end
        end

        res.frame_kind     = wsd_pkg::kind_of(opcode_reg, fin_reg);
        res.payload_length = length_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEAD1;
            opcode_reg <= '0;
            fin_reg    <= 1'b0;
            masked_reg <= 1'b0;
            code_reg   <= '0;
            count_reg  <= '0;
            length_reg <= '0;
            key_reg    <= '0;
            index_reg  <= '0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            fin_reg    <= fin_next;
            masked_reg <= masked_next;
            code_reg   <= code_next;
            count_reg  <= count_next;
            length_reg <= length_next;
            key_reg    <= key_next;
            index_reg  <= index_next;
        end
    end

    `WSD_ASSERT(a_empty_is_final, !(res_valid && res.empty_frame) ||
        (res.last_byte && (res.payload_byte == 8'd0)), "empty result not final or nonzero")
    `WSD_ASSERT(a_payload_in_range, (phase_reg != PH_PAYLOAD) ||
        (index_reg < length_reg), "payload index ran past frame length")
    `WSD_ASSERT_NEXT(a_last_rewinds, take && res_valid && res.last_byte,
        phase_reg == PH_HEAD1, "parser did not return to header after last beat")

endmodule

>>> src/wsd_out_stage.sv
// Result register between the parser and the deframed channel.
// Depends on wsd_pkg, wsd_ifs and assert_macros.svh.
`include "assert_macros.svh"

module wsd_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  wsd_pkg::result_t res,
    output logic             free,
    wsd_frame_if.source      deframed
);

    logic             valid_reg, valid_next;
    wsd_pkg::result_t data_reg;

    // free when empty or the held beat leaves this cycle
    assign free = !valid_reg || deframed.ready;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (deframed.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res;
    end

    assign deframed.valid          = valid_reg;
    assign deframed.payload_byte   = data_reg.payload_byte;
    assign deframed.frame_kind     = data_reg.frame_kind;
    assign deframed.payload_length = data_reg.payload_length;
    assign deframed.last_byte      = data_reg.last_byte;
    assign deframed.empty_frame    = data_reg.empty_frame;

    `WSD_ASSERT_NEXT(a_no_overwrite, valid_reg && !deframed.ready, !load || !$past(load),
        "held beat overwritten while stalled")
    `WSD_ASSERT_NEXT(a_stall_holds, valid_reg && !deframed.ready,
        valid_reg && $stable(data_reg), "held beat changed while stalled")
    `WSD_ASSERT(a_empty_is_last, !valid_reg || !data_reg.empty_frame || data_reg.last_byte,
        "held empty beat not marked last")

endmodule

>>> src/websocket_frame_deframer.sv
// WebSocket (RFC 6455) receive-side frame deframer, top level.
// Depends on wsd_pkg, wsd_ifs, wsd_parser and wsd_out_stage.
//
// Takes one raw stream byte per beat on raw and gives unmasked payload
// bytes on deframed, each with frame kind, 64-bit payload length and a
// last-byte mark; a zero-length frame gives a single empty beat. Header,
// extended length and mask key bytes give no other output beat. A byte
// is taken in every cycle in which the single result register is empty
// or being drained, so the rate is one byte per cycle while deframed is
// ready; a byte's result appears on deframed in the cycle after it is taken.

module websocket_frame_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    wsd_byte_if.sink    raw,
    wsd_frame_if.source deframed
);

    logic             take;
    logic             free;
    logic             res_valid;
    wsd_pkg::result_t res;

    assign raw.ready = free;
    assign take      = raw.valid && free;

    wsd_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (raw.data_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    wsd_out_stage u_out_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (take && res_valid),
        .res      (res),
        .free     (free),
        .deframed (deframed)
    );

endmodule
